// ----- sv/botl_pkg.sv -----
// Shared types and constants for the bucketed ordering table linker.
`default_nettype none

package botl_pkg;

  localparam int ADDR_W     = 24;
  localparam int KIND_W     = 2;
  localparam int BUCKET_W   = 5;
  localparam int BIU_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam int BUCKETS_DEFAULT = 32;

  // Input item kinds.
  localparam logic [KIND_W-1:0] KIND_BUCKET = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EXTRA  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BUILD  = 2'd2;

  // Result kinds.
  localparam logic RES_LINK  = 1'b0;
  localparam logic RES_START = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BUCKETS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_MARKER     = 2'd1;

  localparam logic [BIU_W-1:0]  BUCKETS_IN_USE_RST = 6'd32;
  localparam logic [ADDR_W-1:0] END_MARKER_RST     = '0;

  // One bucket entry as held in the bucket memory.
  typedef struct packed {
    logic [ADDR_W-1:0] first;
    logic [ADDR_W-1:0] last;
  } entry_t;

endpackage

`default_nettype wire

// ----- sv/bucketed_ordering_table_linker_top.sv -----
// Top level of the bucketed ordering table linker: sequencer, list state and result register.
//
// Usage. Items arrive on the input channel (in_valid_i, in_stall_o) with kind_i, item_addr_i
// and bucket_i. Kind 0 appends an item to a depth bucket, kind 1 appends it to the unsorted
// extra list, kind 2 builds the table. Results leave on the output channel (out_valid_o,
// out_stall_i) as link writes (target gets value as its link) or one table start address;
// last_o marks the final result of an item. Configuration writes use cfg_valid_i/cfg_ready_o
// and must only be issued while the block is idle; the block itself does not enforce this.
// Timing. The block handles one item at a time and stalls its input meanwhile. A bucket
// append is one read-modify-write of the bucket memory. A build walks the bucket memory
// through its single read port, scanning buckets_in_use buckets (capped at BUCKETS); a
// stalled receiver holds up any item that still has a result to issue.
// Results pass through a single output register, so the next item may be accepted while the
// last result still waits; when the receiver stalls, the sequencer holds in place until the
// register is free and no result is lost.
// Reset. All lists are emptied at once through per-bucket valid bits, so no clearing pass is
// needed; buckets_in_use returns to 32 and end_marker_addr to zero.
`default_nettype none

module bucketed_ordering_table_linker_top #(
  parameter int BUCKETS = botl_pkg::BUCKETS_DEFAULT
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Input channel
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [botl_pkg::KIND_W-1:0]      kind_i,
  input  wire logic [botl_pkg::ADDR_W-1:0]      item_addr_i,
  input  wire logic [botl_pkg::BUCKET_W-1:0]    bucket_i,
  // Output channel
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic                                  result_kind_o,
  output logic      [botl_pkg::ADDR_W-1:0]      target_addr_o,
  output logic      [botl_pkg::ADDR_W-1:0]      value_addr_o,
  output logic                                  last_o,
  // Configuration channel
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [botl_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [botl_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  import botl_pkg::*;

  localparam int IW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam logic [BIU_W-1:0] BUCKETS_C = BIU_W'(BUCKETS);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_APP    = 3'd1;
  localparam logic [2:0] ST_XAPP   = 3'd2;
  localparam logic [2:0] ST_SRD    = 3'd3;
  localparam logic [2:0] ST_SPROC  = 3'd4;
  localparam logic [2:0] ST_BFIN   = 3'd5;
  localparam logic [2:0] ST_BXEND  = 3'd6;
  localparam logic [2:0] ST_BSTART = 3'd7;

  logic [2:0]        state_q, state_d;
  logic [BIU_W-1:0]  buckets_in_use_q;
  logic [ADDR_W-1:0] end_marker_q;
  logic [ADDR_W-1:0] extra_first_q, extra_first_d;
  logic [ADDR_W-1:0] extra_last_q, extra_last_d;
  logic [ADDR_W-1:0] item_q, item_d;
  logic [IW-1:0]     addr_q, addr_d;
  logic [BIU_W-1:0]  scan_cnt_q, scan_cnt_d;
  logic              found_q, found_d;
  logic [ADDR_W-1:0] tail_q, tail_d;
  logic [ADDR_W-1:0] start_q, start_d;
  logic [BUCKETS-1:0] valid_q;
  logic              rd_valid_q;

  logic [BIU_W-1:0]  count;
  logic [BIU_W-1:0]  bucket_ext;
  logic [BIU_W-1:0]  scan_m1;
  logic              bucket_in_range;
  logic [BUCKETS-1:0] clr_mask;

  logic              ram_we, ram_re;
  logic [IW-1:0]     ram_raddr;
  entry_t            ram_wdata, ram_rdata;
  logic [ADDR_W-1:0] rd_first, rd_last;

  logic              need_emit, go, emit, clr_valid;
  logic              e_kind, e_last;
  logic [ADDR_W-1:0] e_tgt, e_val;
  logic              out_free;

  // The scan never goes past the buckets that physically exist.
  assign count = (buckets_in_use_q > BUCKETS_C) ? BUCKETS_C : buckets_in_use_q;
  assign bucket_ext = BIU_W'(bucket_i);
  assign bucket_in_range = bucket_ext < BUCKETS_C;
  assign scan_m1 = scan_cnt_q - 1'b1;

  always_comb begin
    for (int i = 0; i < BUCKETS; i++) begin
      clr_mask[i] = BIU_W'(i) < count;
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_o || !out_stall_i;

  // Bucket memory: first and last address of each bucket in one word.
  assign ram_raddr = (state_q == ST_IDLE) ? bucket_ext[IW-1:0] : scan_m1[IW-1:0];
  assign ram_re    = ((state_q == ST_IDLE) && in_valid_i && (kind_i == KIND_BUCKET)
                      && bucket_in_range) || (state_q == ST_SRD);

  botl_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (BUCKETS)
  ) u_bucket_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // An entry never written since the last clear reads as empty.
  assign rd_first = rd_valid_q ? ram_rdata.first : '0;
  assign rd_last  = rd_valid_q ? ram_rdata.last  : '0;

  // Which result, if any, the current state wants to issue.
  always_comb begin
    need_emit = 1'b0;
    e_kind    = RES_LINK;
    e_tgt     = '0;
    e_val     = '0;
    e_last    = 1'b0;
    case (state_q)
      ST_APP: begin
        if (rd_last != '0) begin
          need_emit = 1'b1;
          e_tgt     = rd_last;
          e_val     = item_q;
          e_last    = 1'b1;
        end
      end
      ST_XAPP: begin
        if (extra_last_q != '0) begin
          need_emit = 1'b1;
          e_tgt     = extra_last_q;
          e_val     = item_q;
          e_last    = 1'b1;
        end
      end
      ST_SPROC: begin
        if (found_q && (rd_first != '0)) begin
          need_emit = 1'b1;
          e_tgt     = tail_q;
          e_val     = rd_first;
        end
      end
      ST_BFIN: begin
        if (!found_q) begin
          if (extra_last_q != '0) begin
            need_emit = 1'b1;
            e_tgt     = extra_last_q;
            e_val     = end_marker_q;
          end
        end else begin
          need_emit = 1'b1;
          e_tgt     = tail_q;
          e_val     = (extra_first_q != '0) ? extra_first_q : end_marker_q;
        end
      end
      ST_BXEND: begin
        need_emit = 1'b1;
        e_tgt     = extra_last_q;
        e_val     = end_marker_q;
      end
      ST_BSTART: begin
        need_emit = 1'b1;
        e_kind    = RES_START;
        e_val     = start_q;
        e_last    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // A state only advances once its result, if any, fits into the output register.
  assign go   = !need_emit || out_free;
  assign emit = need_emit && go;

  assign ram_we = (state_q == ST_APP) && go;
  assign ram_wdata.first = (rd_last != '0) ? rd_first : item_q;
  assign ram_wdata.last  = item_q;

  always_comb begin
    state_d       = state_q;
    extra_first_d = extra_first_q;
    extra_last_d  = extra_last_q;
    item_d        = item_q;
    addr_d        = addr_q;
    scan_cnt_d    = scan_cnt_q;
    found_d       = found_q;
    tail_d        = tail_q;
    start_d       = start_q;
    clr_valid     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d = item_addr_i;
          addr_d = bucket_ext[IW-1:0];
          case (kind_i)
            KIND_BUCKET: begin
              if (bucket_in_range) begin
                state_d = ST_APP;
              end
            end
            KIND_EXTRA: begin
              state_d = ST_XAPP;
            end
            KIND_BUILD: begin
              found_d    = 1'b0;
              tail_d     = '0;
              scan_cnt_d = count;
              state_d    = (count == '0) ? ST_BFIN : ST_SRD;
            end
            default: begin
            end
          endcase
        end
      end
      ST_APP: begin
        if (go) begin
          state_d = ST_IDLE;
        end
      end
      ST_XAPP: begin
        if (go) begin
          extra_last_d = item_q;
          if (extra_last_q == '0) begin
            extra_first_d = item_q;
          end
          state_d = ST_IDLE;
        end
      end
      ST_SRD: begin
        scan_cnt_d = scan_m1;
        state_d    = ST_SPROC;
      end
      ST_SPROC: begin
        if (go) begin
          if (!found_q) begin
            if (rd_last != '0) begin
              found_d = 1'b1;
              tail_d  = rd_last;
              start_d = rd_first;
            end
          end else if (rd_first != '0) begin
            tail_d = rd_last;
          end
          state_d = (scan_cnt_q == '0) ? ST_BFIN : ST_SRD;
        end
      end
      ST_BFIN: begin
        if (go) begin
          if (!found_q) begin
            extra_last_d = '0;
            if (extra_last_q != '0) begin
              extra_first_d = '0;
              start_d       = extra_first_q;
            end else begin
              start_d = end_marker_q;
            end
            state_d = ST_BSTART;
          end else begin
            clr_valid = 1'b1;
            state_d   = (extra_first_q != '0) ? ST_BXEND : ST_BSTART;
          end
        end
      end
      ST_BXEND: begin
        if (go) begin
          extra_first_d = '0;
          extra_last_d  = '0;
          state_d       = ST_BSTART;
        end
      end
      ST_BSTART: begin
        if (go) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      buckets_in_use_q <= BUCKETS_IN_USE_RST;
      end_marker_q     <= END_MARKER_RST;
      extra_first_q    <= '0;
      extra_last_q     <= '0;
      scan_cnt_q       <= '0;
      found_q          <= 1'b0;
      valid_q          <= '0;
      rd_valid_q       <= 1'b0;
      out_valid_o      <= 1'b0;
    end else begin
      state_q       <= state_d;
      extra_first_q <= extra_first_d;
      extra_last_q  <= extra_last_d;
      scan_cnt_q    <= scan_cnt_d;
      found_q       <= found_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_BUCKETS_IN_USE: buckets_in_use_q <= cfg_data_i[BIU_W-1:0];
          REG_END_MARKER:     end_marker_q     <= cfg_data_i[ADDR_W-1:0];
          default: begin
          end
        endcase
      end
      if (ram_re) begin
        rd_valid_q <= valid_q[ram_raddr];
      end
      if (ram_we) begin
        valid_q[addr_q] <= 1'b1;
      end else if (clr_valid) begin
        valid_q <= valid_q & ~clr_mask;
      end
      if (emit) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // Working registers and result payload carry no reset.
  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    addr_q  <= addr_d;
    tail_q  <= tail_d;
    start_q <= start_d;
    if (emit) begin
      result_kind_o <= e_kind;
      target_addr_o <= e_tgt;
      value_addr_o  <= e_val;
      last_o        <= e_last;
    end
  end

  // A table start is always the final result of a build and has no target.
  a_start_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (result_kind_o == RES_START)) |-> (last_o && (target_addr_o == '0)))
    else $error("table start result without last flag or with a target");

  // The scan counter never points beyond the implemented buckets.
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_cnt_q <= BUCKETS_C)
    else $error("bucket scan counter out of range");

  // An append finishes in the cycle after its memory write.
  a_append_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> (state_q == ST_IDLE))
    else $error("append did not return to idle");

  // A result is only loaded while the output register is free or being drained.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !emit)
    else $error("stalled result overwritten");

endmodule

`default_nettype wire

// ----- sv/botl_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module botl_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- bench/bucketed_ordering_table_linker_top_tb.sv -----
// Self-checking testbench for the bucketed ordering table linker top level.
`default_nettype none

module bucketed_ordering_table_linker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import botl_pkg::*;

  localparam int BUCKETS = BUCKETS_DEFAULT;
  // Long enough for a build to walk every bucket and issue its extra results; this is also
  // the quiet time allowed after the last expected result.
  localparam int DRAIN_CYCLES = 2 * BUCKETS + 8;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 34;
  // The block ignores this kind; the package gives it no name.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // One result of the block: a link write or the table start address.
  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] target;
    logic [ADDR_W-1:0] value;
    logic              last;
  } link_t;

  // How a row of the directed table is treated.
  typedef enum logic [1:0] {
    ROW_WRITE,    // register write; sel is the register index, addr the data
    ROW_PREDICT,  // item checked against the predictor
    ROW_SILENT,   // item that must cause no result
    ROW_ONE       // item that must cause exactly the one result typed in the row
  } row_act_e;

  typedef struct packed {
    row_act_e            act;
    logic [KIND_W-1:0]   sel;
    logic [ADDR_W-1:0]   addr;
    logic [BUCKET_W-1:0] bucket;
    link_t               want;
  } row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [KIND_W-1:0]     kind_i;
  logic [ADDR_W-1:0]     item_addr_i;
  logic [BUCKET_W-1:0]   bucket_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  result_kind_o;
  logic [ADDR_W-1:0]     target_addr_o;
  logic [ADDR_W-1:0]     value_addr_o;
  logic                  last_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  bucketed_ordering_table_linker_top #(
    .BUCKETS(BUCKETS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .item_addr_i  (item_addr_i),
    .bucket_i     (bucket_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_kind_o(result_kind_o),
    .target_addr_o(target_addr_o),
    .value_addr_o (value_addr_o),
    .last_o       (last_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Private copy of the linker state, kept in step with every accepted transfer.
  logic [ADDR_W-1:0] bkt_head [BUCKETS];
  logic [ADDR_W-1:0] bkt_tail [BUCKETS];
  logic [ADDR_W-1:0] loose_head;
  logic [ADDR_W-1:0] loose_tail;
  logic [BIU_W-1:0]  scan_limit;
  logic [ADDR_W-1:0] chain_end;

  link_t batch_q[$];         // results worked out for the latest accepted item
  link_t pending_links[$];   // results still to come out of the block, oldest first
  int    bad_results;
  bit    calm;               // while set, neither side idles nor stalls

  // Clock with a 20 ns period.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog: far beyond the slowest correct run, with every build at its longest and
  // every result held up by the receiver.
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Receiver: stalls in about one cycle in five, except during the calm stretch.
  always @(posedge clk_i) begin
    out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < 20);
  end

  function automatic void report(string msg);
    if (bad_results < 10) begin
      $display("%s", msg);
    end
    bad_results++;
  endfunction

  // Works out the results of one item into batch_q and updates the private state. An
  // append links the old last item of its list to the new one; a build chains the
  // non-empty buckets from the highest scanned one downwards, then the loose list, then
  // the end marker, and closes with the start address.
  function automatic void predict_links(input logic [KIND_W-1:0] kind,
                                        input logic [ADDR_W-1:0] addr,
                                        input logic [BUCKET_W-1:0] bkt);
    int                count;
    int                idx;
    bit                found;
    logic [ADDR_W-1:0] tail;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] old_tail;
    logic [ADDR_W-1:0] old_head;

    batch_q.delete();
    if (kind == KIND_BUCKET) begin
      if (int'(bkt) < BUCKETS) begin
        old_tail = bkt_tail[bkt];
        bkt_tail[bkt] = addr;
        if (old_tail != '0) begin
          batch_q.push_back({RES_LINK, old_tail, addr, 1'b0});
        end else begin
          bkt_head[bkt] = addr;
        end
      end
    end else if (kind == KIND_EXTRA) begin
      old_tail = loose_tail;
      loose_tail = addr;
      if (old_tail != '0) begin
        batch_q.push_back({RES_LINK, old_tail, addr, 1'b0});
      end else begin
        loose_head = addr;
      end
    end else if (kind == KIND_BUILD) begin
      // Registers above the bucket count saturate.
      count = (int'(scan_limit) > BUCKETS) ? BUCKETS : int'(scan_limit);
      idx = count;
      found = 1'b0;
      tail = '0;
      while (idx > 0 && !found) begin
        idx--;
        if (bkt_tail[idx] != '0) begin
          tail = bkt_tail[idx];
          found = 1'b1;
        end
      end
      if (!found) begin
        // Nothing in the scanned buckets: only the loose list, if any, is linked before the start.
        old_tail = loose_tail;
        old_head = loose_head;
        loose_tail = '0;
        if (old_tail != '0) begin
          loose_head = '0;
          batch_q.push_back({RES_LINK, old_tail, chain_end, 1'b0});
          batch_q.push_back({RES_START, {ADDR_W{1'b0}}, old_head, 1'b0});
        end else begin
          batch_q.push_back({RES_START, {ADDR_W{1'b0}}, chain_end, 1'b0});
        end
      end else begin
        start = bkt_head[idx];
        while (idx > 0) begin
          idx--;
          if (bkt_head[idx] != '0) begin
            batch_q.push_back({RES_LINK, tail, bkt_head[idx], 1'b0});
            tail = bkt_tail[idx];
          end
        end
        for (int i = 0; i < count; i++) begin
          bkt_head[i] = '0;
          bkt_tail[i] = '0;
        end
        if (loose_head != '0) begin
          batch_q.push_back({RES_LINK, tail, loose_head, 1'b0});
          batch_q.push_back({RES_LINK, loose_tail, chain_end, 1'b0});
          loose_head = '0;
          loose_tail = '0;
        end else begin
          batch_q.push_back({RES_LINK, tail, chain_end, 1'b0});
        end
        batch_q.push_back({RES_START, {ADDR_W{1'b0}}, start, 1'b0});
      end
    end
    if (batch_q.size() > 0) begin
      batch_q[batch_q.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic row_t mk_row(row_act_e act, logic [KIND_W-1:0] sel,
                                  logic [ADDR_W-1:0] addr, logic [BUCKET_W-1:0] bkt,
                                  logic want_kind, logic [ADDR_W-1:0] want_target,
                                  logic [ADDR_W-1:0] want_value);
    row_t r;
    r.act = act;
    r.sel = sel;
    r.addr = addr;
    r.bucket = bkt;
    r.want = {want_kind, want_target, want_value, 1'b1};
    return r;
  endfunction

  // Drops valid and waits until every expected result has left the block, then lets the
  // block finish any append that causes no result.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_links.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Register writes happen only with the block idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == REG_BUCKETS_IN_USE) begin
      scan_limit = data[BIU_W-1:0];
    end else if (idx == REG_END_MARKER) begin
      chain_end = data[ADDR_W-1:0];
    end
  endtask

  // Offers one item and returns at the edge where the transfer takes place. Valid stays
  // high afterwards so that back-to-back items leave no gap.
  task automatic send_item(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                           logic [BUCKET_W-1:0] bkt);
    if (!calm && $urandom_range(99) < 20) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= kind;
    item_addr_i <= addr;
    bucket_i    <= bkt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Every result taken by the receiver is held against the oldest expectation.
  always @(posedge clk_i) begin : watch_results
    link_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_links.size() == 0) begin
        report($sformatf("unexpected result: kind=%0d target=%06h value=%06h last=%0d",
                         result_kind_o, target_addr_o, value_addr_o, last_o));
      end else begin
        want = pending_links.pop_front();
        if (result_kind_o !== want.kind || target_addr_o !== want.target ||
            value_addr_o !== want.value || last_o !== want.last) begin
          report($sformatf({"result mismatch: expected kind=%0d target=%06h value=%06h ",
                            "last=%0d, got kind=%0d target=%06h value=%06h last=%0d"},
                           want.kind, want.target, want.value, want.last,
                           result_kind_o, target_addr_o, value_addr_o, last_o));
        end
      end
    end
  end

  initial begin : stimulus
    row_t                plan[$];
    row_t                r;
    logic [KIND_W-1:0]   kind;
    logic [ADDR_W-1:0]   addr;
    logic [BUCKET_W-1:0] bkt;
    logic [BIU_W-1:0]    biu;
    logic [ADDR_W-1:0]   marker;
    int                  roll;
    int                  span;

    // Every input known from time zero; reset held asserted before the run starts.
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    kind_i      <= KIND_BUCKET;
    item_addr_i <= '0;
    bucket_i    <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= REG_BUCKETS_IN_USE;
    cfg_data_i  <= '0;
    calm = 1'b0;
    bad_results = 0;
    for (int i = 0; i < BUCKETS; i++) begin
      bkt_head[i] = '0;
      bkt_tail[i] = '0;
    end
    loose_head = '0;
    loose_tail = '0;
    scan_limit = BUCKETS_IN_USE_RST;
    chain_end  = END_MARKER_RST;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table. Typed results carry last set, as each is the only one of its item.
    // A build straight after reset sees no item at all and starts at the zero marker.
    plan.push_back(mk_row(ROW_ONE, KIND_BUILD, 24'h000000, 5'd0, RES_START, 24'h0, 24'h0));
    // The unused kind is dropped, whatever its fields hold.
    plan.push_back(mk_row(ROW_SILENT, KIND_UNUSED, 24'hFFFFFF, 5'd31, RES_LINK, '0, '0));
    plan.push_back(mk_row(ROW_SILENT, KIND_BUCKET, 24'hFFFFFF, 5'd0, RES_LINK, '0, '0));
    plan.push_back(mk_row(ROW_ONE, KIND_BUCKET, 24'h000001, 5'd0,
                          RES_LINK, 24'hFFFFFF, 24'h000001));
    plan.push_back(mk_row(ROW_SILENT, KIND_BUCKET, 24'h123456, 5'd31, RES_LINK, '0, '0));
    // The bucket field means nothing to the loose list.
    plan.push_back(mk_row(ROW_SILENT, KIND_EXTRA, 24'h800000, 5'd31, RES_LINK, '0, '0));
    plan.push_back(mk_row(ROW_ONE, KIND_EXTRA, 24'h7FFFFF, 5'd0,
                          RES_LINK, 24'h800000, 24'h7FFFFF));
    // Highest and lowest bucket joined, then the loose list appended to the chain.
    plan.push_back(mk_row(ROW_PREDICT, KIND_BUILD, 24'hFFFFFF, 5'd31, RES_LINK, '0, '0));
    // Only bucket zero holds anything.
    plan.push_back(mk_row(ROW_SILENT, KIND_BUCKET, 24'h000010, 5'd0, RES_LINK, '0, '0));
    plan.push_back(mk_row(ROW_PREDICT, KIND_BUILD, 24'h000000, 5'd0, RES_LINK, '0, '0));
    // Empty buckets but a loose item.
    plan.push_back(mk_row(ROW_SILENT, KIND_EXTRA, 24'h55AA55, 5'd0, RES_LINK, '0, '0));
    plan.push_back(mk_row(ROW_PREDICT, KIND_BUILD, 24'h000000, 5'd0, RES_LINK, '0, '0));
    // An item at address zero leaves its bucket looking empty to the next append.
    plan.push_back(mk_row(ROW_SILENT, KIND_BUCKET, 24'h000000, 5'd7, RES_LINK, '0, '0));
    plan.push_back(mk_row(ROW_SILENT, KIND_BUCKET, 24'h0000AA, 5'd7, RES_LINK, '0, '0));
    plan.push_back(mk_row(ROW_PREDICT, KIND_BUILD, 24'h000000, 5'd0, RES_LINK, '0, '0));
    // A single scanned bucket: bucket five stays out of the build and keeps its items.
    plan.push_back(mk_row(ROW_WRITE, REG_END_MARKER, 24'hFFFFFF, 5'd0, RES_LINK, '0, '0));
    plan.push_back(mk_row(ROW_WRITE, REG_BUCKETS_IN_USE, 24'd1, 5'd0, RES_LINK, '0, '0));
    plan.push_back(mk_row(ROW_SILENT, KIND_BUCKET, 24'h000505, 5'd5, RES_LINK, '0, '0));
    plan.push_back(mk_row(ROW_SILENT, KIND_BUCKET, 24'h000100, 5'd0, RES_LINK, '0, '0));
    plan.push_back(mk_row(ROW_PREDICT, KIND_BUILD, 24'h000000, 5'd0, RES_LINK, '0, '0));
    // No bucket scanned at all: the build is empty and starts at the end marker.
    plan.push_back(mk_row(ROW_WRITE, REG_BUCKETS_IN_USE, 24'd0, 5'd0, RES_LINK, '0, '0));
    plan.push_back(mk_row(ROW_ONE, KIND_BUILD, 24'h000000, 5'd0,
                          RES_START, 24'h0, 24'hFFFFFF));
    // A bucket count beyond the bucket memory saturates and picks bucket five up again.
    plan.push_back(mk_row(ROW_WRITE, REG_BUCKETS_IN_USE, 24'hFFFFFF, 5'd0, RES_LINK, '0, '0));
    plan.push_back(mk_row(ROW_PREDICT, KIND_BUILD, 24'h000000, 5'd0, RES_LINK, '0, '0));

    foreach (plan[i]) begin
      r = plan[i];
      if (r.act == ROW_WRITE) begin
        write_reg(r.sel, r.addr);
      end else begin
        send_item(r.sel, r.addr, r.bucket);
        predict_links(r.sel, r.addr, r.bucket);
        if (r.act == ROW_PREDICT) begin
          foreach (batch_q[j]) pending_links.push_back(batch_q[j]);
        end else if (r.act == ROW_ONE) begin
          pending_links.push_back(r.want);
        end
      end
    end

    // Random phases, each under its own register setting. Appends dominate so that the
    // builds find several buckets and a loose list to chain together; each phase closes
    // with a build so that its scanned buckets and loose list are emptied under the same setting.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          biu = 6'd32;
          marker = 24'($urandom_range(24'hFFFFFF));
        end
        1: begin
          biu = 6'd1;
          marker = 24'hFFFFFF;
        end
        2: begin
          biu = 6'd0;
          marker = 24'($urandom_range(24'hFFFFFF));
        end
        3: begin
          biu = 6'd63;
          marker = 24'h000000;
        end
        4: begin
          biu = 6'($urandom_range(31, 2));
          marker = 24'($urandom_range(24'hFFFFFF));
        end
        default: begin
          biu = 6'd32;
          marker = 24'($urandom_range(24'hFFFFFF));
        end
      endcase
      // The bits above the bucket count are don't-care for that register.
      write_reg(REG_BUCKETS_IN_USE, {18'($urandom_range(18'h3FFFF)), biu});
      write_reg(REG_END_MARKER, marker);
      // One long stretch with neither side idling.
      calm = (p == 3);
      span = (int'(scan_limit) > BUCKETS) ? BUCKETS : int'(scan_limit);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Once, the sender holds back until everything owed has come out.
        if (p == 1 && n == PHASE_ITEMS / 2) begin
          settle();
        end
        roll = $urandom_range(99);
        if (n == PHASE_ITEMS - 1 || (roll >= 82 && roll < 94)) begin
          kind = KIND_BUILD;
        end else if (roll < 60) begin
          kind = KIND_BUCKET;
        end else if (roll < 82) begin
          kind = KIND_EXTRA;
        end else begin
          kind = KIND_UNUSED;
        end
        roll = $urandom_range(99);
        if (roll < 3) begin
          addr = '0;
        end else if (roll < 6) begin
          addr = 24'hFFFFFF;
        end else begin
          addr = 24'($urandom_range(24'hFFFFFF, 1));
        end
        if (span > 0 && $urandom_range(99) < 70) begin
          bkt = 5'($urandom_range(span - 1));
        end else begin
          bkt = 5'($urandom_range(BUCKETS - 1));
        end
        send_item(kind, addr, bkt);
        predict_links(kind, addr, bkt);
        foreach (batch_q[j]) pending_links.push_back(batch_q[j]);
      end
      calm = 1'b0;
    end

    // Wait for the last results, then a while longer for anything unexpected.
    settle();
    if (bad_results == 0 && pending_links.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
sv/botl_pkg.sv
sv/botl_ram.sv
sv/bucketed_ordering_table_linker_top.sv
bench/bucketed_ordering_table_linker_top_tb.sv
